@@ design/sbw_pkg.sv @@
// shared types and constants for the shifted bitmap write unit
// no dependencies; used by every module of the block except sbw_ram

package sbw_pkg;

   // field widths
   localparam int ADDR_W  = 13;
   localparam int PIX_W   = 8;
   localparam int SHIFT_W = 3;
   localparam int MODE_W  = 8;
   localparam int COLOR_W = 4;

   // one stored entry: color code above the video byte
   localparam int WORD_W = COLOR_W + PIX_W;

   // stream and register port widths
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 24;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;

   // parameter defaults
   localparam int VIDEO_BYTES_DEF = 8192;
   localparam int ROW_STRIDE_DEF  = 256;

   // draw modes
   localparam logic [MODE_W-1:0] MODE_REPLACE = 8'd0;
   localparam logic [MODE_W-1:0] MODE_OR      = 8'd1;
   localparam logic [MODE_W-1:0] MODE_ERASE   = 8'd13;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SHIFT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MODE  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COLOR = 2'd2;

   // controller to datapath
   typedef struct packed {
      logic clr_wr;     // write zero at the sweep counter
      logic load_req;   // capture the accepted word
      logic wr_first;   // compute and write back the first entry
      logic wr_second;  // write back the second entry
      logic load_rsp;   // move the finished result to the output register
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic clear_last; // sweep counter at its last entry
      logic rsp_free;   // output register can take a result this cycle
   } sts_type;

endpackage

@@ design/sbw_ram.sv @@
// generic single-write, dual-read memory with registered read data
// no dependencies

module sbw_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 8192
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic [WIDTH-1:0]         rd_data_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
   end

endmodule

@@ design/sbw_ctrl.sv @@
// sequencing state machine: clearing sweep, read, two write-backs, result hand-off
// depends on sbw_pkg

module sbw_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  sbw_pkg::sts_type sts,
   output sbw_pkg::cmd_type cmd
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WRITE1,
      ST_WRITE2,
      ST_HOLD
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clr_wr = 1'b1;
            if (sts.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = ST_WRITE1;
            end
         end
         ST_WRITE1: begin
            cmd.wr_first = 1'b1;
            state_in     = ST_WRITE2;
         end
         ST_WRITE2: begin
            cmd.wr_second = 1'b1;
            if (sts.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (sts.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ design/sbw_datapath.sv @@
// address generation, bitmap memory, shift/merge logic and result register
// depends on sbw_pkg and sbw_ram

module sbw_datapath #(
   parameter int VIDEO_BYTES = sbw_pkg::VIDEO_BYTES_DEF,
   parameter int ROW_STRIDE  = sbw_pkg::ROW_STRIDE_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  sbw_pkg::cmd_type            cmd,
   output sbw_pkg::sts_type            sts,
   input  logic [sbw_pkg::ADDR_W-1:0]  byte_address,
   input  logic [sbw_pkg::PIX_W-1:0]   pixel_byte,
   input  logic [sbw_pkg::SHIFT_W-1:0] shift_amount,
   input  logic [sbw_pkg::MODE_W-1:0]  draw_mode,
   input  logic [sbw_pkg::COLOR_W-1:0] draw_color,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [sbw_pkg::PIX_W-1:0]   first_byte,
   output logic [sbw_pkg::PIX_W-1:0]   second_byte,
   output logic [sbw_pkg::COLOR_W-1:0] first_color,
   output logic [sbw_pkg::COLOR_W-1:0] second_color,
   output logic                        mode_unsupported
);

   // memory depth is a power of two, so wrapping is truncation
   localparam int AW = $clog2(VIDEO_BYTES);
   localparam int EW = (AW > sbw_pkg::ADDR_W) ? AW : sbw_pkg::ADDR_W;
   localparam int WW = sbw_pkg::WORD_W;
   localparam int PW = sbw_pkg::PIX_W;
   localparam int CW = sbw_pkg::COLOR_W;
   localparam logic [AW-1:0] STRIDE = AW'(ROW_STRIDE % VIDEO_BYTES);

   logic [EW-1:0] addr_ext;
   logic [AW-1:0] a1_now;
   logic [AW-1:0] a2_now;

   logic [AW-1:0] a1_ff;
   logic [AW-1:0] a2_ff;
   logic [PW-1:0] pix_ff;
   logic [AW-1:0] clr_cnt_ff;
   logic [AW-1:0] clr_cnt_in;

   logic [WW-1:0] rd1;
   logic [WW-1:0] rd2;

   logic [2*PW-1:0] pattern;
   logic [2*PW-1:0] mask;
   logic [2*PW-1:0] window;
   logic [2*PW-1:0] merged;
   logic            paint;
   logic            bad_now;
   logic            alias_hit;
   logic [PW-1:0]   b1_new;
   logic [PW-1:0]   b2_new;
   logic [CW-1:0]   c1_new;
   logic [CW-1:0]   c2_new;

   logic [WW-1:0] w1_ff;
   logic [WW-1:0] w2_ff;
   logic          bad_ff;

   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [WW-1:0] wr_data;

   logic          rsp_valid_ff;
   logic          rsp_valid_in;
   logic [WW-1:0] rsp_w1_ff;
   logic [WW-1:0] rsp_w2_ff;
   logic          rsp_bad_ff;

   assign addr_ext = EW'(byte_address);
   assign a1_now   = addr_ext[AW-1:0];
   assign a2_now   = a1_now + STRIDE;

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         a1_ff  <= a1_now;
         a2_ff  <= a2_now;
         pix_ff <= pixel_byte;
      end
   end

   // read both entries while the request is being accepted
   sbw_ram #(
      .WIDTH (WW),
      .DEPTH (VIDEO_BYTES)
   ) u_ram (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (a1_now),
      .rd_data_a (rd1),
      .rd_addr_b (a2_now),
      .rd_data_b (rd2)
   );

   // shift/merge on the 16-bit window
   assign pattern   = {pix_ff, PW'(0)} >> shift_amount;
   assign mask      = {{PW{1'b1}}, PW'(0)} >> shift_amount;
   assign window    = {rd1[PW-1:0], rd2[PW-1:0]};
   assign alias_hit = (a1_ff == a2_ff);

   always_comb begin
      paint   = 1'b0;
      bad_now = 1'b0;
      merged  = window;
      case (draw_mode)
         sbw_pkg::MODE_REPLACE: begin
            paint  = 1'b1;
            merged = (window & ~mask) | pattern;
         end
         sbw_pkg::MODE_OR: begin
            paint  = 1'b1;
            merged = window | pattern;
         end
         sbw_pkg::MODE_ERASE: begin
            merged = window & ~pattern;
         end
         default: begin
            bad_now = 1'b1;
         end
      endcase
   end

   assign b1_new = merged[2*PW-1:PW];
   assign b2_new = merged[PW-1:0];
   assign c1_new = (paint && (|pattern[2*PW-1:PW])) ? draw_color : rd1[WW-1:PW];
   // on an aliased pair the second write sees what the first one left
   assign c2_new = (paint && (|pattern[PW-1:0])) ? draw_color :
                   (alias_hit ? c1_new : rd2[WW-1:PW]);

   always_ff @(posedge clock) begin
      if (cmd.wr_first) begin
         w1_ff  <= {c1_new, b1_new};
         w2_ff  <= {c2_new, b2_new};
         bad_ff <= bad_now;
      end
   end

   // single write port: sweep, first entry, second entry
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = a2_ff;
      wr_data = w2_ff;
      if (cmd.clr_wr) begin
         wr_en   = 1'b1;
         wr_addr = clr_cnt_ff;
         wr_data = '0;
      end else if (cmd.wr_first) begin
         wr_en   = ~bad_now;
         wr_addr = a1_ff;
         wr_data = {c1_new, b1_new};
      end else if (cmd.wr_second) begin
         wr_en = ~bad_ff;
      end
   end

   assign clr_cnt_in = cmd.clr_wr ? clr_cnt_ff + AW'(1) : clr_cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else begin
         clr_cnt_ff <= clr_cnt_in;
      end
   end

   // result register
   assign rsp_valid_in = cmd.load_rsp | (rsp_valid_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_w1_ff  <= alias_hit ? w2_ff : w1_ff;
         rsp_w2_ff  <= w2_ff;
         rsp_bad_ff <= bad_ff;
      end
   end

   assign sts.clear_last = &clr_cnt_ff;
   assign sts.rsp_free   = ~rsp_valid_ff | rsp_ready;

   assign rsp_valid        = rsp_valid_ff;
   assign first_byte       = rsp_w1_ff[PW-1:0];
   assign second_byte      = rsp_w2_ff[PW-1:0];
   assign first_color      = rsp_w1_ff[WW-1:PW];
   assign second_color     = rsp_w2_ff[WW-1:PW];
   assign mode_unsupported = rsp_bad_ff;

endmodule

@@ design/shifted_bitmap_write_unit_core.sv @@
// top level of the shifted bitmap write unit: ports, register file, assertions
// depends on sbw_pkg, sbw_ctrl, sbw_datapath (and sbw_ram below it)

// Usage
//   req channel: one word per processor write, carrying the byte address and
//   the pixel byte. The byte is shifted right by shift_amount across the
//   entry at the address and the entry one row stride on (wrapping in the
//   bitmap) and merged per draw_mode; replace and OR also set draw_color on
//   each entry that gets a set bit.
//   rsp channel: one word per request with both entries after the operation
//   and their color codes; tuser flags a draw mode that is not supported, in
//   which case nothing is written.
//   csr channel: register writes, always ready; write only while idle.
//   Timing: the memory is read at the accept edge, the first entry is
//   written back on the next cycle and the second on the one after; the
//   result is loaded then, or later while the output register is full.
//   The single write port takes the two write-backs in turn, so words are
//   taken one at a time; the output register lets the next word enter
//   while a result waits. Reset: a clearing pass writes zero to every
//   entry, with req_tready low. A stalled receiver holds the result
//   register; a second finished item then waits inside until it is taken.
//   VIDEO_BYTES must be a power of two.

module shifted_bitmap_write_unit_core #(
   parameter int VIDEO_BYTES = sbw_pkg::VIDEO_BYTES_DEF,
   parameter int ROW_STRIDE  = sbw_pkg::ROW_STRIDE_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   // request stream
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // [12:0] byte_address, [20:13] pixel_byte, [23:21] unused
   input  logic [sbw_pkg::REQ_DATA_W-1:0] req_tdata,
   // result stream
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // [7:0] first_byte, [15:8] second_byte, [19:16] first_color,
   // [23:20] second_color
   output logic [sbw_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // [0] mode_unsupported
   output logic                           rsp_tuser,
   // register writes
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [sbw_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [sbw_pkg::CSR_DATA_W-1:0] csr_data
);

   sbw_pkg::cmd_type cmd;
   sbw_pkg::sts_type sts;

   logic [sbw_pkg::SHIFT_W-1:0] shift_ff;
   logic [sbw_pkg::SHIFT_W-1:0] shift_in;
   logic [sbw_pkg::MODE_W-1:0]  mode_ff;
   logic [sbw_pkg::MODE_W-1:0]  mode_in;
   logic [sbw_pkg::COLOR_W-1:0] color_ff;
   logic [sbw_pkg::COLOR_W-1:0] color_in;

   logic [sbw_pkg::PIX_W-1:0]   first_byte;
   logic [sbw_pkg::PIX_W-1:0]   second_byte;
   logic [sbw_pkg::COLOR_W-1:0] first_color;
   logic [sbw_pkg::COLOR_W-1:0] second_color;

   // register file: always ready, indexes past the list are dropped
   assign csr_ready = 1'b1;

   always_comb begin
      shift_in = shift_ff;
      mode_in  = mode_ff;
      color_in = color_ff;
      if (csr_valid) begin
         unique case (csr_index)
            sbw_pkg::CSR_SHIFT: shift_in = csr_data[sbw_pkg::SHIFT_W-1:0];
            sbw_pkg::CSR_MODE:  mode_in  = csr_data[sbw_pkg::MODE_W-1:0];
            sbw_pkg::CSR_COLOR: color_in = csr_data[sbw_pkg::COLOR_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff <= '0;
         mode_ff  <= '0;
         color_ff <= '0;
      end else begin
         shift_ff <= shift_in;
         mode_ff  <= mode_in;
         color_ff <= color_in;
      end
   end

   sbw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .sts       (sts),
      .cmd       (cmd)
   );

   sbw_datapath #(
      .VIDEO_BYTES (VIDEO_BYTES),
      .ROW_STRIDE  (ROW_STRIDE)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .byte_address     (req_tdata[sbw_pkg::ADDR_W-1:0]),
      .pixel_byte       (req_tdata[sbw_pkg::ADDR_W +: sbw_pkg::PIX_W]),
      .shift_amount     (shift_ff),
      .draw_mode        (mode_ff),
      .draw_color       (color_ff),
      .rsp_valid        (rsp_tvalid),
      .rsp_ready        (rsp_tready),
      .first_byte       (first_byte),
      .second_byte      (second_byte),
      .first_color      (first_color),
      .second_color     (second_color),
      .mode_unsupported (rsp_tuser)
   );

   assign rsp_tdata = {second_color, first_color, second_byte, first_byte};

   // an accepted word keeps the request side closed while it is in flight
   a_busy_after_accept: assert property (
      @(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready
   ) else $error("request side open right after an accept");

   // a result only appears while an item was in flight
   a_result_from_item: assert property (
      @(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready)
   ) else $error("result appeared with no item in flight");

   // the clearing pass finishes before any word is taken
   a_no_accept_in_clear: assert property (
      @(posedge clock) disable iff (reset)
      cmd.clr_wr |-> !req_tready
   ) else $error("request side open during clearing pass");

endmodule
